[rtl/core/jse_pkg.sv]
// Package for the JSON string escape encoder: item kinds, character codes,
// the escape step result type and the hex digit helper. No dependencies.
`default_nettype none
package jse_pkg;

   typedef enum logic [1:0] {
      KIND_OPEN  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_RAW   = 2'd3
   } kind_type;

   localparam int unsigned CAP_WIDTH = 16;
   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 16'd256;

   // Longest escape sequence is six characters, so a step index needs three bits.
   localparam int unsigned STEP_WIDTH = 3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CTRL_LIMIT     = 8'h20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } esc_step_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] value;
      value = {4'd0, nibble};
      if (nibble < 4'd10) begin
         hex_digit = CHAR_ZERO + value;
      end else begin
         hex_digit = CHAR_LOWER_A + value - 8'd10;
      end
   endfunction

endpackage
`default_nettype wire

[rtl/core/jse_escape.sv]
// Escape step logic: gives the output character for one step of one item and
// whether that step is the final one. Depends on jse_pkg.
`default_nettype none
module jse_escape (
   input  wire jse_pkg::kind_type                    kind,
   input  wire logic [7:0]                           in_byte,
   input  wire logic [jse_pkg::STEP_WIDTH-1:0]       step,
   output jse_pkg::esc_step_type                     result
);

   logic is_pair;
   logic is_ctrl;

   assign is_pair = (in_byte == jse_pkg::CHAR_QUOTE) || (in_byte == jse_pkg::CHAR_BACKSLASH);
   assign is_ctrl = (in_byte < jse_pkg::CTRL_LIMIT);

   always_comb begin
      result.out_byte = in_byte;
      result.last     = 1'b1;
      unique case (kind)
         jse_pkg::KIND_OPEN, jse_pkg::KIND_CLOSE: begin
            result.out_byte = jse_pkg::CHAR_QUOTE;
         end
         jse_pkg::KIND_RAW: begin
            result.out_byte = in_byte;
         end
         jse_pkg::KIND_CHAR: begin
            if (is_pair) begin
               result.out_byte = (step == 3'd0) ? jse_pkg::CHAR_BACKSLASH : in_byte;
               result.last     = (step != 3'd0);
            end else if (is_ctrl) begin
               // Control bytes become a six character unicode escape.
               result.last = (step == 3'd5);
               case (step)
                  3'd0:    result.out_byte = jse_pkg::CHAR_BACKSLASH;
                  3'd1:    result.out_byte = jse_pkg::CHAR_U;
                  3'd2:    result.out_byte = jse_pkg::CHAR_ZERO;
                  3'd3:    result.out_byte = jse_pkg::CHAR_ZERO;
                  3'd4:    result.out_byte = jse_pkg::hex_digit(in_byte[7:4]);
                  default: result.out_byte = jse_pkg::hex_digit(in_byte[3:0]);
               endcase
            end
         end
         default: begin
            result.out_byte = in_byte;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/json_string_escape_encoder_top.sv]
// Top level of the JSON string escape encoder: item register, fill and overflow
// tracking, and the result register. Depends on jse_pkg and jse_escape.
//
// Usage: each req transaction carries one item, the kind in req_tuser and the
// source byte in req_tdata. The block produces one rsp transaction per output
// character: the character, the buffer position, whether it was kept, the
// sticky overflow flag, and rsp_tlast on the final character of the item.
// A character is kept only while position+1 is below the capacity register,
// written through csr_wr_en/csr_wr_data; the user must write it only while the
// block is idle; the block itself does not enforce this. An accepted item goes
// to the item register, then the result register. Throughput is one output
// character per cycle while rsp_tready is high: quotes, raw bytes and plain
// characters give one character per item, quote and backslash escapes two,
// control byte escapes six; the single escape stepper sets this figure. On a stall
// the result register holds, the item register stops stepping and req_tready
// falls while an item is held. Reset clears fill and overflow, capacity to 256.
`default_nettype none
module json_string_escape_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [7:0] out_byte, [23:8] out_position,
                                         // [24] kept, [25] overflow_seen, [31:26] zero
   output      logic        rsp_tlast,   // last_of_run
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data  // capacity
);

   localparam int unsigned CW = jse_pkg::CAP_WIDTH;
   localparam int unsigned SW = jse_pkg::STEP_WIDTH;

   logic                    item_vld_ff, item_vld_in;
   jse_pkg::kind_type       item_kind_ff, item_kind_in;
   logic [7:0]              item_byte_ff, item_byte_in;
   logic [SW-1:0]           item_step_ff, item_step_in;

   logic [CW-1:0]           cap_ff, cap_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic                    ovf_ff, ovf_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [CW-1:0]           rsp_pos_ff, rsp_pos_in;
   logic                    rsp_kept_ff, rsp_kept_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   jse_pkg::esc_step_type   esc;
   logic                    advance;
   logic                    req_accept;
   logic                    room;

   jse_escape u_escape (
      .kind    (item_kind_ff),
      .in_byte (item_byte_ff),
      .step    (item_step_ff),
      .result  (esc)
   );

   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || (advance && esc.last);
   assign req_accept = req_tvalid && req_tready;
   assign room       = ({1'b0, fill_ff} + {{CW{1'b0}}, 1'b1}) < {1'b0, cap_ff};

   always_comb begin
      item_vld_in  = item_vld_ff;
      item_kind_in = item_kind_ff;
      item_byte_in = item_byte_ff;
      item_step_in = item_step_ff;
      if (advance) begin
         item_step_in = esc.last ? '0 : item_step_ff + {{(SW-1){1'b0}}, 1'b1};
         if (esc.last) begin
            item_vld_in = 1'b0;
         end
      end
      if (req_accept) begin
         item_vld_in  = 1'b1;
         item_kind_in = jse_pkg::kind_type'(req_tuser);
         item_byte_in = req_tdata;
         item_step_in = '0;
      end
   end

   always_comb begin
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_byte_in = rsp_byte_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_kept_in = rsp_kept_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      rsp_last_in = rsp_last_ff;
      if (advance) begin
         fill_in     = room ? fill_ff + {{(CW-1){1'b0}}, 1'b1} : fill_ff;
         ovf_in      = ovf_ff || !room;
         rsp_vld_in  = 1'b1;
         rsp_byte_in = esc.out_byte;
         rsp_pos_in  = fill_ff;
         rsp_kept_in = room;
         rsp_ovf_in  = ovf_ff || !room;
         rsp_last_in = esc.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff  <= 1'b0;
         item_step_ff <= '0;
         cap_ff       <= jse_pkg::CAPACITY_RESET;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         item_vld_ff  <= item_vld_in;
         item_step_ff <= item_step_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff <= item_kind_in;
      item_byte_ff <= item_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, rsp_kept_ff, rsp_pos_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // Once a character has been dropped, the overflow flag never clears.
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

   // A kept character moves the fill position by exactly one.
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (advance && room) |=> (fill_ff == $past(fill_ff) + {{(CW-1){1'b0}}, 1'b1}))
      else $error("fill position did not advance on a kept character");

   // The escape stepper never runs past the six character sequence.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff |-> (item_step_ff <= 3'd5))
      else $error("escape step index out of range");
`endif

endmodule
`default_nettype wire
